>>> rtl/ndm_pkg.sv
// Shared types and constants of the nearest descriptor matcher.
package ndm_pkg;

   localparam int DIST_W = 41;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [DIST_W-1:0] THRESHOLD_RESET = 41'd96636764;
   localparam logic [6:0] COUNT_RESET = 7'd1;
   localparam int ABS_LIMIT_W = 21;

   typedef enum logic {
      OP_GALLERY = 1'b0,
      OP_QUERY   = 1'b1
   } op_type;

   typedef enum logic {
      CSR_CANDIDATE_COUNT = 1'b0,
      CSR_MATCH_THRESHOLD = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type             op;
      logic [5:0]         entry_index;
      logic [6:0]         component_index;
      logic signed [15:0] component_value;
      logic               query_last;
   } req_type;

   typedef struct packed {
      logic [5:0]        best_index;
      logic [DIST_W-1:0] best_distance_sq;
      logic              match_found;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

>>> rtl/ndm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ndm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ndm_mac.sv
// Squared-distance datapath: subtract, magnitude, square, saturating accumulate.
module ndm_mac #(
   parameter int COMPONENT_BITS = 16,
   parameter int IDX_W = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ndm_pkg::mac_ctl_type         issue_ctl,
   input  logic [IDX_W-1:0]             issue_entry,
   input  logic [COMPONENT_BITS-1:0]    query_comp,
   input  logic [COMPONENT_BITS-1:0]    gallery_comp,
   output logic                         out_valid,
   output logic [ndm_pkg::DIST_W-1:0]   out_dist,
   output logic [IDX_W-1:0]             out_entry
);
   import ndm_pkg::*;

   localparam int CB = COMPONENT_BITS;

   mac_ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic [IDX_W-1:0] s1_entry_ff, s2_entry_ff, s3_entry_ff;
   logic [ABS_LIMIT_W-1:0] s2_abs_ff, s2_abs_in;
   logic s2_over_ff, s2_over_in, s3_over_ff;
   logic [2*ABS_LIMIT_W-1:0] s3_sq_ff, s3_sq_in;
   logic [DIST_W-1:0] acc_ff, acc_in;
   logic sat_ff, sat_in;
   logic out_valid_ff;
   logic [DIST_W-1:0] out_dist_ff, out_dist_in;
   logic [IDX_W-1:0] out_entry_ff;

   logic signed [CB:0] diff;
   logic [CB:0] abs_v;
   logic [63:0] abs_ext;
   logic [DIST_W-1:0] acc_base;
   logic [DIST_W+1:0] sum;

   // Stage 2 works on the registered RAM outputs.
   always_comb begin
      diff = $signed({query_comp[CB-1], query_comp}) -
             $signed({gallery_comp[CB-1], gallery_comp});
      abs_v = diff[CB] ? (CB+1)'(-diff) : (CB+1)'(diff);
      abs_ext = 64'(abs_v);
      s2_over_in = abs_ext > 64'(DIST_MAX >> (DIST_W - ABS_LIMIT_W));
      s2_abs_in = abs_ext[ABS_LIMIT_W-1:0];
   end

   assign s3_sq_in = (2*ABS_LIMIT_W)'(s2_abs_ff) * (2*ABS_LIMIT_W)'(s2_abs_ff);

   // A saturated entry stays saturated until its first component restarts the sum.
   always_comb begin
      acc_base = s3_ctl_ff.first ? '0 : acc_ff;
      sum = (DIST_W+2)'(acc_base) + (DIST_W+2)'(s3_sq_ff);
      sat_in = ((s3_ctl_ff.first ? 1'b0 : sat_ff) | s3_over_ff |
                (sum > (DIST_W+2)'(DIST_MAX)));
      acc_in = sum[DIST_W-1:0];
      out_dist_in = sat_in ? DIST_MAX : sum[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_ctl_ff <= issue_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
         out_valid_ff <= s3_ctl_ff.valid & s3_ctl_ff.last;
      end
      s1_entry_ff <= issue_entry;
      s2_entry_ff <= s1_entry_ff;
      s2_abs_ff <= s2_abs_in;
      s2_over_ff <= s2_over_in;
      s3_entry_ff <= s2_entry_ff;
      s3_sq_ff <= s3_sq_in;
      s3_over_ff <= s2_over_ff;
      if (s3_ctl_ff.valid) begin
         acc_ff <= acc_in;
         sat_ff <= sat_in;
         out_dist_ff <= out_dist_in;
         out_entry_ff <= s3_entry_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_dist = out_dist_ff;
   assign out_entry = out_entry_ff;

endmodule

>>> rtl/nearest_descriptor_matcher_top.sv
// Gallery load, query capture, search sequencer and best-match tracking.
// Gallery and query beats are taken one per cycle while no search runs.
// A search starts at the edge that takes the last query beat; the scan then issues
// one multiply-accumulate per cycle through the single distance unit fed by the
// two RAM read ports.
// Synchronous reset clears control, sets candidate_count to 1 and the threshold
// to 0.6 squared; gallery and query memories are not cleared.
module nearest_descriptor_matcher_top #(
   parameter int MAX_ENTRIES = 64,
   parameter int VECTOR_LENGTH = 128,
   parameter int COMPONENT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ndm_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ndm_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  ndm_pkg::csr_index_type        csr_index,
   input  logic [ndm_pkg::DIST_W-1:0]    csr_wdata
);
   import ndm_pkg::*;

   localparam int IDX_W = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = VECTOR_LENGTH > 1 ? $clog2(VECTOR_LENGTH) : 1;
   localparam int GA_W = IDX_W + CW;
   localparam logic [CW-1:0] COMP_LAST = CW'(VECTOR_LENGTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] comp_ff, comp_in;
   logic [IDX_W-1:0] entry_ff, entry_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic [6:0] count_ff;
   logic [DIST_W-1:0] threshold_ff;

   logic req_fire, csr_fire, search_start;
   logic gal_we, qry_we;
   logic [CW-1:0] wr_comp;
   logic [COMPONENT_BITS-1:0] wr_value;
   logic [COMPONENT_BITS-1:0] gal_rdata, qry_rdata;
   logic [IDX_W-1:0] last_sel;
   mac_ctl_type issue_ctl;
   logic dist_valid;
   logic [DIST_W-1:0] mac_dist;
   logic [IDX_W-1:0] dist_entry;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire = csr_valid & csr_ready;

   assign wr_comp = CW'(req_data.component_index);
   assign wr_value = COMPONENT_BITS'($unsigned(req_data.component_value));
   assign gal_we = req_fire && (req_data.op == OP_GALLERY) &&
                   (32'(req_data.entry_index) < MAX_ENTRIES) &&
                   (32'(req_data.component_index) < VECTOR_LENGTH);
   assign qry_we = req_fire && (req_data.op == OP_QUERY) &&
                   (32'(req_data.component_index) < VECTOR_LENGTH);
   assign search_start = req_fire && (req_data.op == OP_QUERY) && req_data.query_last;

   // Zero candidates search one entry; too many search the whole gallery.
   always_comb begin
      if (count_ff == 7'd0) begin
         last_sel = '0;
      end else if (32'(count_ff) > MAX_ENTRIES) begin
         last_sel = IDX_W'(MAX_ENTRIES - 1);
      end else begin
         last_sel = IDX_W'(count_ff - 7'd1);
      end
   end

   ndm_ram #(
      .WIDTH(COMPONENT_BITS),
      .DEPTH(1 << GA_W)
   ) u_gallery (
      .clock(clock),
      .we(gal_we),
      .waddr({IDX_W'(req_data.entry_index), wr_comp}),
      .wdata(wr_value),
      .raddr({entry_ff, comp_ff}),
      .rdata(gal_rdata)
   );

   ndm_ram #(
      .WIDTH(COMPONENT_BITS),
      .DEPTH(VECTOR_LENGTH)
   ) u_query (
      .clock(clock),
      .we(qry_we),
      .waddr(wr_comp),
      .wdata(wr_value),
      .raddr(comp_ff),
      .rdata(qry_rdata)
   );

   assign issue_ctl.valid = (state_ff == ST_SCAN);
   assign issue_ctl.first = (comp_ff == '0);
   assign issue_ctl.last = (comp_ff == COMP_LAST);

   ndm_mac #(
      .COMPONENT_BITS(COMPONENT_BITS),
      .IDX_W(IDX_W)
   ) u_mac (
      .clock(clock),
      .reset(reset),
      .issue_ctl(issue_ctl),
      .issue_entry(entry_ff),
      .query_comp(qry_rdata),
      .gallery_comp(gal_rdata),
      .out_valid(dist_valid),
      .out_dist(mac_dist),
      .out_entry(dist_entry)
   );

   always_comb begin
      state_in = state_ff;
      comp_in = comp_ff;
      entry_in = entry_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in = rsp_data_ff;
      best_dist_in = best_dist_ff;
      best_idx_in = best_idx_ff;

      // Strict compare keeps the earliest entry on ties.
      if (dist_valid && ((dist_entry == '0) || (mac_dist < best_dist_ff))) begin
         best_dist_in = mac_dist;
         best_idx_in = dist_entry;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (search_start) begin
               state_in = ST_SCAN;
               comp_in = '0;
               entry_in = '0;
               last_in = last_sel;
            end
         end
         ST_SCAN: begin
            if (comp_ff == COMP_LAST) begin
               comp_in = '0;
               entry_in = entry_ff + 1'b1;
               if (entry_ff == last_ff) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               comp_in = comp_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (dist_valid && (dist_entry == last_ff)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.best_index = 6'(best_idx_ff);
               rsp_data_in.best_distance_sq = best_dist_ff;
               rsp_data_in.match_found = (best_dist_ff < threshold_ff);
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         best_dist_ff <= '0;
         best_idx_ff <= '0;
         count_ff <= COUNT_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         best_dist_ff <= best_dist_in;
         best_idx_ff <= best_idx_in;
         if (csr_fire) begin
            unique case (csr_index)
               CSR_CANDIDATE_COUNT: count_ff <= csr_wdata[6:0];
               CSR_MATCH_THRESHOLD: threshold_ff <= csr_wdata;
            endcase
         end
      end
      comp_ff <= comp_in;
      entry_ff <= entry_in;
      last_ff <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_dist_only_in_search: assert property (@(posedge clock) disable iff (reset)
      dist_valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance result outside a search");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish state");

   a_last_starts_scan: assert property (@(posedge clock) disable iff (reset)
      search_start |=> (state_ff == ST_SCAN && comp_ff == '0 && entry_ff == '0))
      else $error("last query beat did not start a scan from entry zero");

endmodule

>>> sim/ndm_check_pkg.sv
// Predictor and result checker for the nearest descriptor matcher testbench.
package ndm_check_pkg;
   import ndm_pkg::*;

   localparam int ENTRY_COUNT = 64;
   localparam int VECTOR_LEN = 128;
   localparam longint ABS_LIMIT = (longint'(1) << ABS_LIMIT_W) - 1;

   class match_tracker;
      logic signed [15:0] gallery [ENTRY_COUNT][VECTOR_LEN];
      logic signed [15:0] query [VECTOR_LEN];
      logic [6:0]         count_reg;
      logic [DIST_W-1:0]  threshold_reg;
      rsp_type            pending_matches [$];
      int                 failures;
      int                 searches;
      int                 requests;

      function new();
         count_reg = COUNT_RESET;
         threshold_reg = THRESHOLD_RESET;
         failures = 0;
         searches = 0;
         requests = 0;
      endfunction

      function void note_config(csr_index_type idx, logic [DIST_W-1:0] value);
         if (idx == CSR_CANDIDATE_COUNT) begin
            count_reg = value[6:0];
         end else begin
            threshold_reg = value;
         end
      endfunction

      function logic [DIST_W-1:0] entry_distance(int entry);
         longint sum;
         longint diff;
         sum = 0;
         for (int i = 0; i < VECTOR_LEN; i++) begin
            diff = longint'(query[i]) - longint'(gallery[entry][i]);
            if (diff < 0) diff = -diff;
            if (diff > ABS_LIMIT) return DIST_MAX;
            sum += diff * diff;
            if (sum > longint'(DIST_MAX)) return DIST_MAX;
         end
         return sum[DIST_W-1:0];
      endfunction

      // A later entry wins only when strictly closer, so ties keep the lower index.
      function rsp_type search(logic [6:0] count_value);
         int                span;
         rsp_type           best;
         logic [DIST_W-1:0] entry_dist;
         span = int'(count_value);
         if (span < 1) span = 1;
         if (span > ENTRY_COUNT) span = ENTRY_COUNT;
         best.best_index = '0;
         best.best_distance_sq = entry_distance(0);
         for (int k = 1; k < span; k++) begin
            entry_dist = entry_distance(k);
            if (entry_dist < best.best_distance_sq) begin
               best.best_distance_sq = entry_dist;
               best.best_index = 6'(k);
            end
         end
         best.match_found = (best.best_distance_sq < threshold_reg);
         return best;
      endfunction

      function void note_request(req_type item);
         requests++;
         if (item.op == OP_GALLERY) begin
            gallery[item.entry_index][item.component_index] = item.component_value;
         end else begin
            query[item.component_index] = item.component_value;
            if (item.query_last) begin
               pending_matches.insert(pending_matches.size(), search(count_reg));
            end
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_matches.size() == 0) begin
            $display("%0t: result with none expected: index %0d distance %0d match %0b",
                     $time, got.best_index, got.best_distance_sq, got.match_found);
            failures++;
            return;
         end
         want = pending_matches.pop_front();
         searches++;
         if (got.best_index !== want.best_index) begin
            $display("%0t: best_index expected %0d actual %0d",
                     $time, want.best_index, got.best_index);
            failures++;
         end
         if (got.best_distance_sq !== want.best_distance_sq) begin
            $display("%0t: best_distance_sq expected %0d actual %0d",
                     $time, want.best_distance_sq, got.best_distance_sq);
            failures++;
         end
         if (got.match_found !== want.match_found) begin
            $display("%0t: match_found expected %0b actual %0b",
                     $time, want.match_found, got.match_found);
            failures++;
         end
      endfunction

      function int outstanding();
         return pending_matches.size();
      endfunction
   endclass

endpackage

>>> sim/nearest_descriptor_matcher_top_test.sv
// Testbench top: drives gallery loads, queries and register writes, and checks every match.
module nearest_descriptor_matcher_top_test;
   import ndm_pkg::*;
   import ndm_check_pkg::*;

   typedef enum int {
      THR_ZERO,
      THR_FULL,
      THR_RESET,
      THR_NEAR
   } thr_mode_type;

   // The initial fill loads this many gallery entries, and no phase searches beyond them.
   localparam int GALLERY_FILL = 6;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   csr_index_type     csr_index;
   logic [DIST_W-1:0] csr_wdata;

   match_tracker board = new();
   int           max_gap = 6;
   int           settings_used = 0;

   nearest_descriptor_matcher_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (csr_valid && csr_ready) board.note_config(csr_index, csr_wdata);
      end
   end

   function automatic req_type make_req(op_type op, int entry, int comp,
                                        logic signed [15:0] value, logic last);
      req_type item;
      item.op = op;
      item.entry_index = 6'(entry);
      item.component_index = 7'(comp);
      item.component_value = value;
      item.query_last = last;
      return item;
   endfunction

   function automatic logic signed [15:0] pick_value();
      unique case ($urandom_range(15))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_req(input req_type item);
      int gap;
      gap = $urandom_range(max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // The first edge lets the monitor record a search started by the last beat.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic configure(input logic [6:0] count, input logic [DIST_W-1:0] limit);
      csr_index <= CSR_CANDIDATE_COUNT;
      csr_wdata <= DIST_W'(count);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_MATCH_THRESHOLD;
      csr_wdata <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // In the near mode, a threshold near the current best distance makes later queries fall on both sides.
   task automatic start_phase(input logic [6:0] count, input thr_mode_type mode,
                              input int gap);
      rsp_type           probe;
      logic [DIST_W-1:0] limit;
      settle();
      probe = board.search(count);
      unique case (mode)
         THR_ZERO:  limit = '0;
         THR_FULL:  limit = DIST_MAX;
         THR_RESET: limit = THRESHOLD_RESET;
         default: begin
            if ($urandom_range(1)) limit = probe.best_distance_sq + (probe.best_distance_sq >> 5);
            else limit = probe.best_distance_sq - (probe.best_distance_sq >> 5);
         end
      endcase
      configure(count, limit);
      max_gap = gap;
   endtask

   task automatic run_random(input int budget);
      int                 sent;
      int                 span;
      int                 len;
      int                 pick;
      int                 entry;
      int                 comp;
      logic signed [15:0] value;
      sent = 0;
      while (sent < budget) begin
         span = int'(board.count_reg);
         if (span < 1) span = 1;
         if (span > ENTRY_COUNT) span = ENTRY_COUNT;
         pick = $urandom_range(99);
         if (pick < 70) begin
            if ($urandom_range(49) == 0) settle();
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++) begin
               send_req(make_req(OP_QUERY, $urandom_range(63), $urandom_range(127),
                                 pick_value(), i == len - 1));
            end
            sent += len;
         end else if (pick < 88) begin
            // Writing the same component to both entries of a pair keeps ties alive.
            entry = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(span - 1);
            comp = $urandom_range(127);
            value = pick_value();
            send_req(make_req(OP_GALLERY, entry, comp, value, 1'($urandom_range(1))));
            sent++;
            if ($urandom_range(1)) begin
               send_req(make_req(OP_GALLERY, entry ^ 1, comp, value, 1'($urandom_range(1))));
               sent++;
            end
         end else begin
            send_req(make_req(OP_QUERY, $urandom_range(63), $urandom_range(127),
                              pick_value(), 1'b0));
            sent++;
         end
      end
   endtask

   initial begin : result_side
      int gap;
      rsp_ready <= 1'b0;
      forever begin
         gap = $urandom_range(max_gap);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      rsp_type            probe;
      logic signed [15:0] twin [VECTOR_LEN];
      logic signed [15:0] value;
      logic [DIST_W-1:0]  exact;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_CANDIDATE_COUNT;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      configure(7'd2, THRESHOLD_RESET);

      // Fill the searched part of the gallery; its entries come in identical pairs.
      for (int e = 0; e < GALLERY_FILL; e++) begin
         for (int c = 0; c < VECTOR_LEN; c++) begin
            if (e < 16 && (e % 2) == 1) begin
               value = twin[c];
            end else begin
               value = pick_value();
               twin[c] = value;
            end
            send_req(make_req(OP_GALLERY, e, c, value, 1'b0));
         end
      end
      for (int c = 0; c < VECTOR_LEN; c++) begin
         send_req(make_req(OP_QUERY, $urandom_range(63), c, pick_value(), c == VECTOR_LEN - 1));
      end

      send_req(make_req(OP_GALLERY, 63, 127, 16'sh7FFF, 1'b1));
      send_req(make_req(OP_GALLERY, 0, 0, 16'sh8000, 1'b0));
      send_req(make_req(OP_GALLERY, 1, 0, 16'sh8000, 1'b0));
      send_req(make_req(OP_QUERY, 63, 0, 16'sh7FFF, 1'b1));
      send_req(make_req(OP_QUERY, 0, 127, 16'sh8000, 1'b1));
      send_req(make_req(OP_QUERY, 21, 64, 16'sh0000, 1'b0));
      send_req(make_req(OP_QUERY, 42, 0, 16'sh8000, 1'b1));

      // A distance equal to the threshold must not match; with a threshold one above it, it must.
      settle();
      probe = board.search(board.count_reg);
      exact = probe.best_distance_sq;
      configure(board.count_reg, exact);
      send_req(make_req(OP_QUERY, 0, 0, 16'sh8000, 1'b1));
      settle();
      configure(board.count_reg, exact + 1'b1);
      send_req(make_req(OP_QUERY, 0, 0, 16'sh8000, 1'b1));

      start_phase(7'd3, THR_NEAR, 6);
      run_random(40);
      start_phase(7'd0, THR_RESET, 0);
      run_random(30);
      start_phase(7'd6, THR_NEAR, 6);
      run_random(40);
      start_phase(7'd2, THR_ZERO, 6);
      run_random(30);
      start_phase(7'd6, THR_FULL, 0);
      run_random(30);
      start_phase(7'd5, THR_NEAR, 3);
      run_random(30);
      start_phase(7'd1, THR_NEAR, 6);
      run_random(30);

      settle();
      repeat (240) @(posedge clock);
      $display("Sent %0d request beats and checked %0d search results under %0d register settings.",
               board.requests, board.searches, settings_used);
      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(100_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
